// ===== sv/mdcs_pkg.sv =====
// Shared types, constants and helpers for the matrix display command serializer.
`timescale 1ns / 1ps
`default_nettype none
package mdcs_pkg;

  localparam int ROWS       = 7;
  localparam int DIGITS     = 8;
  localparam int ROW_W      = 5;
  localparam int ROW_SLOTS  = 8;
  localparam int ROW_BITS   = ROW_W * ROW_SLOTS;
  localparam int DATA_W     = 35;
  localparam int BYTE_CNT_W = 4;

  localparam logic [7:0] CTRL_BASE = 8'b1100_0000;
  localparam logic [7:0] ADDR_BASE = 8'b1010_0000;
  localparam logic [7:0] NCLR_BIT  = 8'b0010_0000;
  localparam logic [7:0] PEAK_BIT  = 8'b0001_0000;
  localparam logic [7:0] ZERO_BYTE = 8'b0000_0000;
  localparam logic [4:0] ROW_MASK  = 5'b11111;
  localparam logic [2:0] BR_MAX    = 3'b111;

  typedef enum logic [2:0] {
    KIND_RESET  = 3'd0,
    KIND_CLEAR  = 3'd1,
    KIND_BRIGHT = 3'd2,
    KIND_PEAK   = 3'd3,
    KIND_DIGIT  = 3'd4
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last_byte;
    logic       rst_pulse;
  } byte_req_t;

  function automatic logic [7:0] ctrl_byte(input logic clr, input logic peak,
                                           input logic [2:0] br);
    logic [7:0] b;
    b = CTRL_BASE | {5'd0, br};
    if (!clr) b = b | NCLR_BIT;
    if (peak) b = b | PEAK_BIT;
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/matrix_display_command_serializer_core.sv =====
// Top level: dot-matrix display command serializer.
// Each data byte is shifted out bit by bit; a reset command yields one result.
// Path: sequencer command register, shifter byte register, output register.
// A digit write sends up to eight bytes; the input stalls until its last byte is taken.
// Reset clears the control mirror (brightness code, peak current) and all handshakes.
`timescale 1ns / 1ps
`default_nettype none
module matrix_display_command_serializer_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [2:0]                   kind,
  input  wire  [7:0]                   digit,
  input  wire  [2:0]                   brightness,
  input  wire                          low_peak,
  input  wire  [mdcs_pkg::DATA_W-1:0]  row_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         serial_bit,
  output logic                         end_of_byte,
  output logic                         reset_pulse,
  output logic                         last
);

  mdcs_pkg::byte_req_t req;
  logic                take;

  mdcs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .digit      (digit),
    .brightness (brightness),
    .low_peak   (low_peak),
    .row_data   (row_data),
    .take       (take),
    .req        (req)
  );

  mdcs_shift u_shift (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_bit  (serial_bit),
    .end_of_byte (end_of_byte),
    .reset_pulse (reset_pulse),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== sv/mdcs_seq.sv =====
// Command sequencer: holds the control mirror and hands out bytes one at a time.
`timescale 1ns / 1ps
`default_nettype none
module mdcs_seq (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [2:0]                       kind,
  input  wire  [7:0]                       digit,
  input  wire  [2:0]                       brightness,
  input  wire                              low_peak,
  input  wire  [mdcs_pkg::DATA_W-1:0]      row_data,
  input  wire                              take,
  output mdcs_pkg::byte_req_t              req
);

  logic                                  busy;
  logic [2:0]                            cmd;
  logic [2:0]                            addr;
  logic                                  has_addr;
  logic [mdcs_pkg::ROW_BITS-1:0]         rows;
  logic [mdcs_pkg::BYTE_CNT_W-1:0]       byte_idx;
  logic [mdcs_pkg::BYTE_CNT_W-1:0]       n_bytes;
  logic [2:0]                            bright_code;
  logic                                  peak_low;
  logic                                  accept;
  logic                                  last_byte;
  logic                                  addr_phase;
  logic [7:0]                            data;

  assign in_stall   = busy;
  assign accept     = in_valid && !busy;
  assign last_byte  = (byte_idx == n_bytes - mdcs_pkg::BYTE_CNT_W'(1));
  assign addr_phase = has_addr && (byte_idx == '0);

  always_comb begin
    case (cmd)
      mdcs_pkg::KIND_RESET: data = mdcs_pkg::ZERO_BYTE;
      mdcs_pkg::KIND_CLEAR: data = mdcs_pkg::ctrl_byte(byte_idx == '0, peak_low, bright_code);
      mdcs_pkg::KIND_BRIGHT,
      mdcs_pkg::KIND_PEAK:  data = mdcs_pkg::ctrl_byte(1'b0, peak_low, bright_code);
      mdcs_pkg::KIND_DIGIT: begin
        if (addr_phase) data = mdcs_pkg::ADDR_BASE | {5'd0, addr};
        else data = {3'd0, rows[mdcs_pkg::ROW_W-1:0] & mdcs_pkg::ROW_MASK};
      end
      default:              data = mdcs_pkg::ZERO_BYTE;
    endcase
  end

  always_comb begin
    req.valid     = busy;
    req.data      = data;
    req.last_byte = last_byte;
    req.rst_pulse = (cmd == mdcs_pkg::KIND_RESET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      bright_code <= '0;
      peak_low    <= 1'b0;
      byte_idx    <= '0;
      n_bytes     <= '0;
      cmd         <= mdcs_pkg::KIND_RESET;
    end else if (accept) begin
      cmd      <= kind;
      addr     <= digit[2:0];
      has_addr <= (digit < 8'(mdcs_pkg::DIGITS));
      rows     <= mdcs_pkg::ROW_BITS'(row_data);
      byte_idx <= '0;
      case (kind)
        mdcs_pkg::KIND_RESET: begin
          bright_code <= '0;
          peak_low    <= 1'b0;
          n_bytes     <= mdcs_pkg::BYTE_CNT_W'(1);
          busy        <= 1'b1;
        end
        mdcs_pkg::KIND_CLEAR: begin
          n_bytes <= mdcs_pkg::BYTE_CNT_W'(2);
          busy    <= 1'b1;
        end
        mdcs_pkg::KIND_BRIGHT: begin
          bright_code <= mdcs_pkg::BR_MAX - brightness;
          n_bytes     <= mdcs_pkg::BYTE_CNT_W'(1);
          busy        <= 1'b1;
        end
        mdcs_pkg::KIND_PEAK: begin
          peak_low <= low_peak;
          n_bytes  <= mdcs_pkg::BYTE_CNT_W'(1);
          busy     <= 1'b1;
        end
        mdcs_pkg::KIND_DIGIT: begin
          n_bytes <= mdcs_pkg::BYTE_CNT_W'(mdcs_pkg::ROWS)
                   + mdcs_pkg::BYTE_CNT_W'(digit < 8'(mdcs_pkg::DIGITS));
          busy    <= 1'b1;
        end
        default: busy <= 1'b0;
      endcase
    end else if (take) begin
      byte_idx <= byte_idx + mdcs_pkg::BYTE_CNT_W'(1);
      if (cmd == mdcs_pkg::KIND_DIGIT && !addr_phase) begin
        rows <= rows >> mdcs_pkg::ROW_W;
      end
      if (last_byte) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mdcs_shift.sv =====
// Byte shifter: one bit per unstalled cycle, LSB first, via an output register.
`timescale 1ns / 1ps
`default_nettype none
module mdcs_shift (
  input  wire                       clk,
  input  wire                       rst,
  input  wire mdcs_pkg::byte_req_t  req,
  output logic                      take,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      serial_bit,
  output logic                      end_of_byte,
  output logic                      reset_pulse,
  output logic                      last
);

  logic       sh_busy;
  logic [7:0] sh_byte;
  logic [2:0] bit_cnt;
  logic       sh_last;
  logic       sh_rst;
  logic       advance;
  logic       finish;

  assign advance = sh_busy && (!out_valid || !out_stall);
  assign finish  = sh_rst || (bit_cnt == 3'd7);
  assign take    = req.valid && (!sh_busy || (advance && finish));

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_busy   <= 1'b0;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
      if (advance) begin
        serial_bit  <= sh_rst ? 1'b0 : sh_byte[0];
        end_of_byte <= !sh_rst && (bit_cnt == 3'd7);
        reset_pulse <= sh_rst;
        last        <= sh_last && finish;
      end
      if (take) begin
        sh_busy <= 1'b1;
        sh_byte <= req.data;
        sh_last <= req.last_byte;
        sh_rst  <= req.rst_pulse;
        bit_cnt <= '0;
      end else if (advance) begin
        sh_byte <= sh_byte >> 1;
        bit_cnt <= bit_cnt + 3'd1;
        if (finish) sh_busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
